// ----- design/tlssni_pkg.sv -----
// ----------------------------------------------------------------------------
// TLS SNI extract and hash: shared package
// Result codes, configuration register indexes, widths and the constants of
// the ClientHello parser and the FNV-1a 64 hash.
// ----------------------------------------------------------------------------
`default_nettype none

package tlssni_pkg;

	// Default for the number of payload bytes that are parsed.
	localparam int MAX_PAYLOAD_DEF = 8192;

	// Configuration port.
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] CFG_EXT_LIMIT  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_NAME_LIMIT = CFG_IDX_W'(1);

	localparam int EXT_LIMIT_W  = 5;
	localparam int NAME_LIMIT_W = 7;
	localparam logic [EXT_LIMIT_W-1:0]  EXT_LIMIT_RST  = EXT_LIMIT_W'(20);
	localparam logic [NAME_LIMIT_W-1:0] NAME_LIMIT_RST = NAME_LIMIT_W'(64);

	// Result status codes.
	localparam logic [1:0] STATUS_NOT_TLS = 2'd0;
	localparam logic [1:0] STATUS_NO_SNI  = 2'd1;
	localparam logic [1:0] STATUS_HASH    = 2'd2;

	// Record and handshake header.
	localparam logic [7:0] REC_TYPE_HANDSHAKE = 8'h16;
	localparam logic [7:0] HS_TYPE_CLIENT_HELLO = 8'h01;
	localparam int REC_TYPE_POS  = 0;
	localparam int HS_TYPE_POS   = 5;
	localparam int SID_LEN_POS   = 43;
	localparam int SID_START_POS = 44;

	// Extension type of server_name, and the bytes from the end of its type
	// field to the high byte of the first name length.
	localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;
	localparam int SNI_NAME_LEN_SKIP = 6;

	// FNV-1a 64.
	localparam logic [63:0] FNV_BASIS  = 64'hcbf29ce484222325;
	localparam logic [63:0] HASH_ONES  = 64'hFFFFFFFFFFFFFFFF;
	localparam logic [63:0] HASH_REMAP = 64'hFFFFFFFFFFFFFFFE;

	typedef struct packed {
		logic [EXT_LIMIT_W-1:0]  ext_limit;
		logic [NAME_LIMIT_W-1:0] name_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] sni_hash;
	} result_t;

endpackage

`default_nettype wire

// ----- design/tlssni_cfg.sv -----
// ----------------------------------------------------------------------------
// TLS SNI extract and hash: configuration registers
// Holds the extension limit and the server name length limit.
// ----------------------------------------------------------------------------
`default_nettype none

module tlssni_cfg import tlssni_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	logic [EXT_LIMIT_W-1:0]  ext_limit_q;
	logic [NAME_LIMIT_W-1:0] name_limit_q;
	logic                    wr;

	assign cfg_ready = 1'b1;
	assign wr = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_limit_q  <= EXT_LIMIT_RST;
			name_limit_q <= NAME_LIMIT_RST;
		end else if (wr) begin
			// Writes to an index beyond the two registers are dropped.
			if (cfg_index == CFG_EXT_LIMIT) begin
				ext_limit_q <= cfg_data[EXT_LIMIT_W-1:0];
			end
			if (cfg_index == CFG_NAME_LIMIT) begin
				name_limit_q <= cfg_data[NAME_LIMIT_W-1:0];
			end
		end
	end

	assign cfg.ext_limit  = ext_limit_q;
	assign cfg.name_limit = name_limit_q;

endmodule

`default_nettype wire

// ----- design/tlssni_fnv.sv -----
// ----------------------------------------------------------------------------
// TLS SNI extract and hash: FNV-1a 64 step
// Lower-cases one name byte, folds it into the hash and multiplies by the
// FNV prime as a sum of shifted copies.
// ----------------------------------------------------------------------------
`default_nettype none

module tlssni_fnv (
	input  wire logic [63:0] hash_in,
	input  wire logic [7:0]  name_byte,
	output logic [63:0]      hash_out
);

	logic [7:0]  lc;
	logic [63:0] x;

	always_comb begin
		lc = name_byte;
		if (name_byte >= 8'h41 && name_byte <= 8'h5A) begin
			lc = name_byte + 8'd32;
		end
	end

	assign x = hash_in ^ {56'd0, lc};

	// The prime is 2^40 + 0x1b3, and 0x1b3 is 256 + 128 + 32 + 16 + 2 + 1.
	assign hash_out = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4)
		+ (x << 1) + x;

endmodule

`default_nettype wire

// ----- design/tlssni_parser.sv -----
// ----------------------------------------------------------------------------
// TLS SNI extract and hash: ClientHello parser
// Walks the record one byte a cycle on step, jumping over variable-length
// fields, hashes the server name and forms the result on the final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tlssni_parser import tlssni_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cfg_t       cfg,
	input  wire logic       step,
	input  wire logic [7:0] byte_in,
	input  wire logic       last_in,
	output result_t         result
);

	localparam int PosW = $clog2(MAX_PAYLOAD + 1);
	localparam int TgtW = ((PosW > 16) ? PosW : 16) + 2;
	localparam logic [PosW-1:0] MaxPos = PosW'(MAX_PAYLOAD);
	localparam logic [TgtW-1:0] MaxTgt = TgtW'(MAX_PAYLOAD);

	typedef enum logic [3:0] {
		PH_HDR, PH_CS_HI, PH_CS_LO, PH_COMP, PH_EL_HI, PH_EL_LO, PH_ET_HI,
		PH_ET_LO, PH_XL_HI, PH_XL_LO, PH_NL_HI, PH_NL_LO, PH_NAME, PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		DEC_NONE, DEC_NOT_TLS, DEC_ERROR, DEC_HASH
	} dec_t;

	phase_t                  phase_q, phase_n, jmp_ph;
	dec_t                    dec_q, dec_n, dec_val;
	logic [PosW-1:0]         pos_q, pos_n, tgt_q, tgt_n;
	logic [7:0]              fhb_q, fhb_n;
	logic [EXT_LIMIT_W-1:0]  cnt_q, cnt_n, ext_cnt;
	logic [NAME_LIMIT_W-1:0] left_q, left_n, name_len;
	logic [63:0]             hash_q, hash_n, fnv_out;
	logic                    handle, do_jump, do_ext, do_finish, do_decide;
	logic [TgtW-1:0]         jmp_tgt, pt;
	logic [15:0]             v16;

	tlssni_fnv u_fnv (
		.hash_in  (hash_q),
		.name_byte(byte_in),
		.hash_out (fnv_out)
	);

	assign pt  = TgtW'(pos_q);
	assign v16 = {fhb_q, byte_in};
	assign handle = (phase_q != PH_DONE) && (pos_q < MaxPos)
		&& ((phase_q == PH_HDR) || (pos_q == tgt_q));

	always_comb begin
		phase_n   = phase_q;
		dec_n     = dec_q;
		tgt_n     = tgt_q;
		fhb_n     = fhb_q;
		cnt_n     = cnt_q;
		left_n    = left_q;
		hash_n    = hash_q;
		do_jump   = 1'b0;
		jmp_tgt   = pt + TgtW'(1);
		jmp_ph    = phase_q;
		do_ext    = 1'b0;
		ext_cnt   = cnt_q;
		do_finish = 1'b0;
		do_decide = 1'b0;
		dec_val   = DEC_NONE;
		name_len  = v16[NAME_LIMIT_W-1:0];

		if (handle) begin
			unique case (phase_q)
				PH_HDR: begin
					priority if (pos_q == PosW'(REC_TYPE_POS)
							&& byte_in != REC_TYPE_HANDSHAKE) begin
						do_decide = 1'b1;
						dec_val   = DEC_NOT_TLS;
					end else if (pos_q == PosW'(HS_TYPE_POS)
							&& byte_in != HS_TYPE_CLIENT_HELLO) begin
						do_decide = 1'b1;
						dec_val   = DEC_NOT_TLS;
					end else if (pos_q == PosW'(SID_LEN_POS)) begin
						do_jump = 1'b1;
						jmp_tgt = TgtW'(SID_START_POS) + TgtW'(byte_in);
						jmp_ph  = PH_CS_HI;
					end else begin
					end
				end
				PH_CS_HI, PH_EL_HI, PH_ET_HI, PH_XL_HI, PH_NL_HI: begin
					fhb_n   = byte_in;
					do_jump = 1'b1;
					unique case (phase_q)
						PH_CS_HI: jmp_ph = PH_CS_LO;
						PH_EL_HI: jmp_ph = PH_EL_LO;
						PH_ET_HI: jmp_ph = PH_ET_LO;
						PH_XL_HI: jmp_ph = PH_XL_LO;
						default:  jmp_ph = PH_NL_LO;
					endcase
				end
				PH_CS_LO: begin
					do_jump = 1'b1;
					jmp_tgt = pt + TgtW'(1) + TgtW'(v16);
					jmp_ph  = PH_COMP;
				end
				PH_COMP: begin
					do_jump = 1'b1;
					jmp_tgt = pt + TgtW'(1) + TgtW'(byte_in);
					jmp_ph  = PH_EL_HI;
				end
				PH_EL_LO: begin
					do_ext = 1'b1;
				end
				PH_ET_LO: begin
					do_jump = 1'b1;
					if (v16 == EXT_SERVER_NAME) begin
						jmp_tgt = pt + TgtW'(SNI_NAME_LEN_SKIP);
						jmp_ph  = PH_NL_HI;
					end else begin
						jmp_ph = PH_XL_HI;
					end
				end
				PH_XL_LO: begin
					cnt_n   = cnt_q + EXT_LIMIT_W'(1);
					ext_cnt = cnt_n;
					do_ext  = 1'b1;
					jmp_tgt = pt + TgtW'(1) + TgtW'(v16);
				end
				PH_NL_LO: begin
					if (v16 > 16'(cfg.name_limit)) begin
						name_len = cfg.name_limit;
					end
					if (name_len == '0) begin
						do_finish = 1'b1;
					end else begin
						left_n  = name_len;
						do_jump = 1'b1;
						jmp_ph  = PH_NAME;
					end
				end
				PH_NAME: begin
					hash_n = fnv_out;
					left_n = left_q - NAME_LIMIT_W'(1);
					if (left_n == '0) begin
						do_finish = 1'b1;
					end else begin
						do_jump = 1'b1;
						jmp_ph  = PH_NAME;
					end
				end
				default: begin
				end
			endcase
		end

		// Every new extension is checked against the limit before its type.
		if (do_ext) begin
			if (ext_cnt >= cfg.ext_limit) begin
				do_decide = 1'b1;
				dec_val   = DEC_ERROR;
			end else begin
				do_jump = 1'b1;
				jmp_ph  = PH_ET_HI;
			end
		end

		// A jump that lands beyond the parsed window counts as truncation.
		if (do_jump) begin
			if (jmp_tgt >= MaxTgt) begin
				do_decide = 1'b1;
				dec_val   = DEC_ERROR;
			end else begin
				tgt_n   = jmp_tgt[PosW-1:0];
				phase_n = jmp_ph;
			end
		end

		if (do_finish) begin
			if (hash_n == '0 || hash_n == HASH_ONES) begin
				hash_n = HASH_REMAP;
			end
			do_decide = 1'b1;
			dec_val   = DEC_HASH;
		end

		if (do_decide) begin
			dec_n   = dec_val;
			phase_n = PH_DONE;
		end

		pos_n = (pos_q < MaxPos) ? pos_q + PosW'(1) : pos_q;

		result.sni_hash = '0;
		if (dec_n == DEC_HASH) begin
			result.status   = STATUS_HASH;
			result.sni_hash = hash_n;
		end else if (dec_n == DEC_NOT_TLS || phase_n == PH_HDR) begin
			result.status = STATUS_NOT_TLS;
		end else begin
			result.status = STATUS_NO_SNI;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			dec_q   <= DEC_NONE;
			pos_q   <= '0;
			tgt_q   <= '0;
			fhb_q   <= '0;
			cnt_q   <= '0;
			left_q  <= '0;
			hash_q  <= FNV_BASIS;
		end else if (step) begin
			if (last_in) begin
				phase_q <= PH_HDR;
				dec_q   <= DEC_NONE;
				pos_q   <= '0;
				tgt_q   <= '0;
				fhb_q   <= '0;
				cnt_q   <= '0;
				left_q  <= '0;
				hash_q  <= FNV_BASIS;
			end else begin
				phase_q <= phase_n;
				dec_q   <= dec_n;
				pos_q   <= pos_n;
				tgt_q   <= tgt_n;
				fhb_q   <= fhb_n;
				cnt_q   <= cnt_n;
				left_q  <= left_n;
				hash_q  <= hash_n;
			end
		end
	end

	// A decision is taken exactly when the parser has finished.
	a_done_decided: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE) == (dec_q != DEC_NONE))
		else $error("parser finished state and decision disagree");

	// The final byte leaves the parser ready for a new packet.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && last_in |=> pos_q == '0 && phase_q == PH_HDR && hash_q == FNV_BASIS)
		else $error("packet state not cleared after final byte");

	// The position stops at the end of the parsed window, and a pending read target lies inside it.
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= MaxPos && (phase_q == PH_HDR || phase_q == PH_DONE || tgt_q < MaxPos))
		else $error("byte position or read target out of range");

endmodule

`default_nettype wire

// ----- design/tls_sni_extract_hash_core.sv -----
// ----------------------------------------------------------------------------
// TLS SNI extract and hash: top level
// Input byte register, ClientHello parser with FNV-1a 64 hash, result
// register and configuration registers.
// ----------------------------------------------------------------------------
// The block takes one TCP payload byte per cycle and gives one result per
// packet, on the transfer of the byte marked last_byte: status 0 when the
// packet is not a TLS ClientHello or ends in its fixed header, 1 when it is
// cut short later or carries no server name within ext_limit extensions,
// and 2 with the lower-cased FNV-1a 64 hash of up to name_limit name bytes
// (0 and all ones become HASH_REMAP). The parser and hash state advance by
// one byte on each transfer, so a byte can be transferred in every cycle; a
// byte is held in the input register, and the result is registered in the
// output register as the final byte leaves the input register. A final byte
// waits in the input register only while an earlier result has not been
// taken. Bytes beyond MAX_PAYLOAD are ignored. Reset sets ext_limit to 20
// and name_limit to 64; registers are to be written only while no packet is
// in flight, and the block itself does not enforce this.
`default_nettype none

module tls_sni_extract_hash_core import tlssni_pkg::*; #(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [7:0]            payload_byte,
	input  wire logic                  last_byte,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [1:0]                 status,
	output logic [63:0]                sni_hash
);

	cfg_t        cfg;
	result_t     result;
	logic        valid_s1, last_s1;
	logic [7:0]  byte_s1;
	logic        res_free, s1_go;
	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [63:0] hash_q;

	tlssni_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	// Only a final byte needs room in the result register.
	assign res_free = !out_valid_q || out_ready;
	assign s1_go    = valid_s1 && (!last_s1 || res_free);
	assign in_ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= payload_byte;
			last_s1 <= last_byte;
		end
	end

	tlssni_parser #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (s1_go),
		.byte_in(byte_s1),
		.last_in(last_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			status_q <= result.status;
			hash_q   <= result.sni_hash;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign sni_hash  = hash_q;

	// A result appears only from the transfer of a final byte.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s1_go && last_s1))
		else $error("result raised without a final byte");

	// A final byte is held back only by a result that has not been taken.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_go |-> last_s1 && out_valid_q && !out_ready)
		else $error("input register stalled without cause");

	// The hash is zero unless it is valid, and never a remapped value.
	a_hash_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != STATUS_HASH |-> hash_q == '0)
		else $error("hash not zero for a result without a hash");

	a_hash_remap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == STATUS_HASH |-> hash_q != '0 && hash_q != HASH_ONES)
		else $error("hash result holds a value that should be remapped");

endmodule

`default_nettype wire
